[sv/rsk_pkg.sv]
// ----------------------------------------------------------------------------
// rsk_pkg: shared definitions for the rotate-sum key hash
// Widths of the key and result fields, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned VbW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = $clog2(WordW);

  localparam logic [WordW-1:0] BucketCountRst = WordW'(1);
  localparam logic [CntW-1:0]  LastDivStep    = CntW'(WordW - 1);

  typedef struct packed {
    logic acc_en;    // Fold the accepted beat into the running sum.
    logic div_load;  // Accepted beat closes the key: start the reduction.
    logic div_step;  // Run one restoring division step.
    logic out_load;  // Move the remainder into the result register.
  } rsk_cmd_t;

  typedef struct packed {
    logic div_last;  // The step counter is at the final division step.
  } rsk_sts_t;

endpackage

[sv/rsk_if.sv]
// ----------------------------------------------------------------------------
// rsk_if: valid/ready channels of the rotate-sum key hash
// One channel carries key beats in, the other carries bucket indexes out.
// ----------------------------------------------------------------------------
interface rsk_in_if import rsk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] key_word;
  logic [VbW-1:0]   valid_bytes;
  logic             last;

  modport source (output valid, output key_word, output valid_bytes, output last,
                  input ready);
  modport sink   (input valid, input key_word, input valid_bytes, input last,
                  output ready);
endinterface

interface rsk_out_if import rsk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

[sv/rsk_ctrl.sv]
// ----------------------------------------------------------------------------
// rsk_ctrl: sequencing for the rotate-sum key hash
// Accepts key beats, runs the division steps and hands the result over.
// ----------------------------------------------------------------------------
module rsk_ctrl import rsk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rsk_sts_t sts_i,
  output rsk_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.acc_en    = accept;
    cmd_o.div_load  = accept & in_last_i;
    unique case (state_q)
      StIdle: begin
        if (accept && in_last_i) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // The result register frees up either when empty or when drained now.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/rsk_dp.sv]
// ----------------------------------------------------------------------------
// rsk_dp: datapath of the rotate-sum key hash
// Running sum, word position, bucket count register, a one-bit-per-cycle
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module rsk_dp import rsk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  input  logic [WordW-1:0] key_word_i,
  input  logic [VbW-1:0]   valid_bytes_i,
  input  rsk_cmd_t         cmd_i,
  output rsk_sts_t         sts_o,
  output logic [WordW-1:0] bucket_index_o
);

  logic [WordW-1:0] sum_q, sum_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] bcount_q;
  logic [WordW-1:0] dvd_q, dvd_d;
  logic [WordW:0]   rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] res_q;

  logic [2*WordW-1:0] rot_wide;
  logic [WordW-1:0]   rot_word;
  logic [WordW-1:0]   part_word;
  logic [WordW-1:0]   addend;
  logic [WordW-1:0]   sum_next;
  logic [PosW-1:0]    pos_next;
  logic               full_word;
  logic [WordW:0]     rem_sh;

  // Values 4 to 7 all count as a full word.
  assign full_word = valid_bytes_i[VbW-1];
  assign rot_wide  = {key_word_i, key_word_i} >> pos_q;
  assign rot_word  = rot_wide[WordW-1:0];

  always_comb begin
    part_word = '0;
    for (int j = 0; j < 3; j++) begin
      if (valid_bytes_i[1:0] > 2'(j)) begin
        part_word = part_word +
                    (WordW'(key_word_i[ByteW*j +: ByteW]) << j);
      end
    end
  end

  assign addend   = full_word ? rot_word : part_word;
  assign sum_next = sum_q + addend;
  assign pos_next = full_word ? pos_q + PosW'(1) : pos_q;

  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    if (cmd_i.acc_en) begin
      sum_d = cmd_i.div_load ? '0 : sum_next;
      pos_d = cmd_i.div_load ? '0 : pos_next;
    end
  end

  // A zero divisor always subtracts nothing, which leaves the dividend itself.
  assign rem_sh = {rem_q[WordW-1:0], dvd_q[WordW-1]};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.div_load) begin
      dvd_d = sum_next;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (rem_sh >= {1'b0, bcount_q}) begin
        rem_d = rem_sh - {1'b0, bcount_q};
      end else begin
        rem_d = rem_sh;
      end
    end
  end

  assign sts_o.div_last = (cnt_q == LastDivStep);
  assign bucket_index_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pos_q    <= '0;
      bcount_q <= BucketCountRst;
      cnt_q    <= '0;
    end else begin
      sum_q <= sum_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        bcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.out_load) begin
      res_q <= rem_q[WordW-1:0];
    end
  end

endmodule

[sv/rotate_sum_key_hash_unit.sv]
// ----------------------------------------------------------------------------
// rotate_sum_key_hash_unit: key to bucket index hash
// Top level that joins the controller, the datapath and the two channels.
// ----------------------------------------------------------------------------
// A key streams in on key_i as beats of four little-endian bytes. A full beat
// is rotated right by its word position and added to a running sum; a short
// beat of one to three bytes adds each byte shifted left by as many bits as its byte index.
// Non-last beats are taken one per cycle, and keep being taken while an
// earlier result still waits on res_o.
// The beat that carries last closes the key. The sum is then reduced modulo
// the bucket count by a restoring divider that retires one quotient bit per
// cycle, so key_i stays not ready after that beat through the 32 division
// steps and the hand-over of the remainder to the result register, after
// which the result is valid on res_o.
// A bucket count of zero passes the raw sum through.
// If res_o is stalled, the finished remainder waits in the divider and key_i
// stays not ready until the result register frees up. The bucket count is
// written through cfg_we_i and cfg_wdata_i; the user must do so only while
// idle, as the block does not enforce it. Reset clears the sum and the word
// position, empties the result register and sets the bucket count to one.
// ----------------------------------------------------------------------------
module rotate_sum_key_hash_unit import rsk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  rsk_in_if.sink           key_i,
  rsk_out_if.source        res_o
);

  rsk_cmd_t cmd;
  rsk_sts_t sts;

  rsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_i.valid),
    .in_last_i   (key_i.last),
    .in_ready_o  (key_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsk_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .key_word_i     (key_i.key_word),
    .valid_bytes_i  (key_i.valid_bytes),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bucket_index_o (res_o.bucket_index)
  );

  // Closing a key starts the reduction, so the input side must go busy.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready && key_i.last) |=> !key_i.ready)
    else $error("input still ready after the closing beat");

  // Beats inside a key stream without a gap.
  a_stream_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready && !key_i.last) |=> key_i.ready)
    else $error("input went busy after a beat inside a key");

  // A new result only appears at the end of a reduction.
  a_result_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> !$past(key_i.ready))
    else $error("result appeared without a reduction");

endmodule

[verif/rsk_hash_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsk_hash_checker: scoreboard for the rotate-sum key hash
// Watches the key and result channels and the bucket count write port. It
// keeps its own running sum to work out each bucket index, and compares every
// result beat with the oldest pending index.
// ----------------------------------------------------------------------------
module rsk_hash_checker import rsk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  rsk_in_if                key_i,
  rsk_out_if               res_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_count_o
);

  logic [WordW-1:0] bucket_count_q = BucketCountRst;
  logic [WordW-1:0] hash_sum_q     = '0;
  logic [PosW-1:0]  word_pos_q     = '0;
  logic [WordW-1:0] pending_index_q[$];
  int unsigned      fails          = 0;

  function automatic logic [WordW-1:0] rotate_right(input logic [WordW-1:0] v,
                                                    input logic [PosW-1:0]  amt);
    logic [2*WordW-1:0] both;
    both = {v, v} >> amt;
    return both[WordW-1:0];
  endfunction

  // Sum after one key beat. Counts of four and above are a full word.
  function automatic logic [WordW-1:0] fold_beat(input logic [WordW-1:0] sum,
                                                 input logic [PosW-1:0]  pos,
                                                 input logic [WordW-1:0] word,
                                                 input logic [VbW-1:0]   nb);
    logic [WordW-1:0] acc;
    acc = sum;
    if (nb >= VbW'(4)) begin
      acc = acc + rotate_right(word, pos);
    end else begin
      for (int j = 0; j < int'(nb); j++) begin
        acc = acc + (WordW'(word[ByteW*j +: ByteW]) << j);
      end
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    logic [WordW-1:0] want;
    if (!rst_ni) begin
      bucket_count_q = BucketCountRst;
      hash_sum_q     = '0;
      word_pos_q     = '0;
      pending_index_q.delete();
    end else begin
      if (cfg_we_i) begin
        bucket_count_q = cfg_wdata_i;
      end

      if (key_i.valid && key_i.ready) begin
        hash_sum_q = fold_beat(hash_sum_q, word_pos_q, key_i.key_word, key_i.valid_bytes);
        if (key_i.valid_bytes >= VbW'(4)) begin
          word_pos_q = word_pos_q + PosW'(1);
        end
        if (key_i.last) begin
          // A zero bucket count passes the raw sum through.
          if (bucket_count_q == '0) begin
            pending_index_q.push_back(hash_sum_q);
          end else begin
            pending_index_q.push_back(hash_sum_q % bucket_count_q);
          end
          hash_sum_q = '0;
          word_pos_q = '0;
        end
      end

      if (res_i.valid && res_i.ready) begin
        if (pending_index_q.size() == 0) begin
          $error("bucket_index beat with nothing pending: expected none, actual %h",
                 res_i.bucket_index);
          fails++;
        end else begin
          want = pending_index_q.pop_front();
          if (res_i.bucket_index !== want) begin
            $error("bucket_index mismatch: expected %h, actual %h",
                   want, res_i.bucket_index);
            fails++;
          end
        end
      end
    end
    fail_count_o    <= fails;
    pending_count_o <= unsigned'(pending_index_q.size());
  end

endmodule

[verif/rotate_sum_key_hash_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_sum_key_hash_unit_test: testbench top for the rotate-sum key hash
// Drives keys into the hash unit under several bucket counts, first a short
// directed set of corner keys and then random keys, with random gaps on both
// channels. A scoreboard beside the unit predicts and checks every index.
// ----------------------------------------------------------------------------
module rotate_sum_key_hash_unit_test import rsk_pkg::*; ();

  // Random beats spread over a number of bucket count phases.
  localparam int unsigned RandomBeats    = 1050;
  localparam int unsigned RandomPhases   = 8;
  // Settle time after the last index is checked; leave some margin.
  localparam int unsigned SettleCycles   = 40;
  // One long stall on the result side, long enough to back the unit up.
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned HoldAfterBeats = 30;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [WordW-1:0] cfg_wdata_i;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned results_seen = 0;
  int unsigned beats_sent   = 0;

  rsk_in_if  key_if ();
  rsk_out_if res_if ();

  rotate_sum_key_hash_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_i       (key_if),
    .res_o       (res_if)
  );

  rsk_hash_checker scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .key_i           (key_if),
    .res_i           (res_if),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Count result beats so the receiver knows when to start its long stall.
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Result side. Each pass sets ready once and then holds it for a while, so
  // ready never takes two assignments in one step. Besides the short random
  // stalls there are stretches of steady ready, and once a long hold-off
  // during which the sender keeps offering beats and the unit fills up.
  initial begin : receiver
    bit          hold_done;
    int unsigned roll;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      roll = $urandom_range(99);
      if (!hold_done && results_seen >= HoldAfterBeats) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else if (roll < 25) begin
        res_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else if (roll < 32) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Offer one key beat and wait for the handshake. valid stays high on return
  // so that back-to-back beats need no second assignment in the same step.
  task automatic send_beat(input logic [WordW-1:0] word, input logic [VbW-1:0] nb,
                           input logic lst);
    key_if.valid       <= 1'b1;
    key_if.key_word    <= word;
    key_if.valid_bytes <= nb;
    key_if.last        <= lst;
    do @(posedge clk_i); while (!key_if.ready);
    beats_sent++;
  endtask

  // Idle the key channel for a number of cycles; zero keeps the stream going.
  task automatic pause_key(input int unsigned gap);
    if (gap != 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every pending index has been checked, then
  // let the unit settle so that it is idle for a bucket count write.
  task automatic drain_results();
    key_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [WordW-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random key. Most keys are full words with a random tail beat; about a
  // fifth are noisy, with short or oversized byte counts mixed into the body.
  // Some keys run past 32 words so that the word position wraps, and some are
  // sent with no gaps at all.
  task automatic send_random_key(input bit long_key);
    int unsigned body_len;
    bit          steady;
    bit          noisy;
    logic [VbW-1:0] nb;
    steady = ($urandom_range(99) < 30);
    noisy  = ($urandom_range(99) < 20);
    if (long_key || $urandom_range(99) < 8) begin
      body_len = $urandom_range(33, 40);
    end else begin
      body_len = $urandom_range(0, 6);
    end
    for (int k = 0; k < int'(body_len); k++) begin
      nb = VbW'(4);
      if (noisy && $urandom_range(99) < 30) begin
        nb = VbW'($urandom_range(0, 7));
      end
      send_beat($urandom(), nb, 1'b0);
      if (!steady) begin
        pause_key(pick_gap());
      end
    end
    if (noisy) begin
      nb = VbW'($urandom_range(0, 7));
    end else begin
      nb = VbW'($urandom_range(0, 4));
    end
    send_beat($urandom(), nb, 1'b1);
    if (!steady) begin
      pause_key(pick_gap());
    end
  endtask

  // Bucket count for each random phase: the extremes first, then one and a power
  // of two, a small odd count, a round count and two random ones.
  function automatic logic [WordW-1:0] phase_bucket_count(input int unsigned phase);
    case (phase)
      0: begin
        return 32'hFFFF_FFFF;
      end
      1: begin
        return 32'h0000_0000;
      end
      2: begin
        return 32'h0000_0001;
      end
      3: begin
        return 32'h8000_0000;
      end
      4: begin
        return 32'd7;
      end
      5: begin
        return 32'd1000;
      end
      6: begin
        return WordW'($urandom_range(2, 64));
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    key_if.valid       <= 1'b0;
    key_if.key_word    <= '0;
    key_if.valid_bytes <= '0;
    key_if.last        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed keys with a zero bucket count, so each index is the raw sum.
    write_bucket_count(32'h0000_0000);
    // Empty key: the word is ignored and the index is zero.
    send_beat(32'hFFFF_FFFF, VbW'(0), 1'b1);
    // Single full words at both extremes.
    send_beat(32'hFFFF_FFFF, VbW'(4), 1'b1);
    send_beat(32'h0000_0000, VbW'(4), 1'b1);
    // Two words: the second one is rotated right by one.
    send_beat(32'h8000_0001, VbW'(4), 1'b0);
    send_beat(32'h0000_0003, VbW'(4), 1'b1);
    // Short keys of one, two and three bytes.
    send_beat(32'hFFFF_FFFF, VbW'(1), 1'b1);
    send_beat(32'hFFFF_FFFF, VbW'(2), 1'b1);
    send_beat(32'hDDCC_BBAA, VbW'(3), 1'b1);
    // Oversized byte counts count as full words.
    send_beat(32'h1234_5678, VbW'(5), 1'b0);
    send_beat(32'h9ABC_DEF0, VbW'(6), 1'b0);
    send_beat(32'h0F0F_0F0F, VbW'(7), 1'b1);
    // Short and empty beats in the middle of a key leave the position alone.
    send_beat(32'hA5A5_A5A5, VbW'(2), 1'b0);
    send_beat(32'h1111_1111, VbW'(4), 1'b0);
    send_beat(32'h0000_00FF, VbW'(0), 1'b0);
    send_beat(32'h2222_2222, VbW'(4), 1'b1);
    drain_results();

    // Largest bucket count: an all-ones sum wraps to zero.
    write_bucket_count(32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFF, VbW'(4), 1'b1);
    send_beat(32'hFFFF_FFFE, VbW'(4), 1'b1);
    drain_results();

    // Random phases. Each phase waits for its last index before the next
    // bucket count is written, so the sender pauses until all results are in.
    for (phase = 0; phase < RandomPhases; phase++) begin
      write_bucket_count(phase_bucket_count(phase));
      target = beats_sent + RandomBeats / RandomPhases;
      send_random_key(1'b1);
      while (beats_sent < target) begin
        send_random_key(1'b0);
      end
      drain_results();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
